/* sv/ep2p_pkg.sv */
// Shared constants and types for the ideal-gas primitive-to-flow converter.
// No dependencies.
package ep2p_pkg;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned QBITS       = 49;

  localparam logic [30:0] GAS_RESET  = 31'd18811847;
  localparam logic [17:0] HEAT_RESET = 18'd91750;
  localparam logic [17:0] G_MIN      = 18'd65537;
  localparam logic [17:0] ONE_Q16    = 18'd65536;

  localparam logic [1:0] REG_GAS  = 2'd0;
  localparam logic [1:0] REG_HEAT = 2'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NEG_ARG = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

endpackage

/* sv/euler_primitive_to_physical.sv */
// Top level: ideal-gas primitive state to pressure, enthalpy, energy, sound speed, speed.
// Depends on ep2p_pkg, ep2p_recip, ep2p_isqrt.
//
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata carry density, velocity and temperature.
//   Result beats leave on m_tvalid/m_tready/m_tdata with status on m_tuser.
//   Registers are written through cfg_we/cfg_index/cfg_data (index 0 gas constant,
//   index 1 heat ratio). The user must write them only while no beat is in flight;
//   the block does not enforce this. Throughput: one beat per cycle while m_tready
//   is high and the divider is idle. Stages from input to output register: three
//   multiply/combine stages, a saturation stage overlapped with a 32-stage
//   square-root pipeline, one output stage. A bit-serial divider computes 1/(gamma-1)
//   after reset and every heat ratio write; s_tready stays low during that time.
//   When the receiver holds m_tready low, the whole pipeline freezes once the
//   output register is full; nothing is dropped or repeated.
//   Reset (rst, synchronous) restores both registers and empties the pipeline.
module euler_primitive_to_physical import ep2p_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // density_in[30:0], vel_x, vel_y, vel_z, temperature_in, pad
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // density_out, pressure, total_enthalpy, total_energy, sound_speed,
  // temperature_out, speed, vx_out, vy_out, vz_out, heat_ratio_out, pad
  output logic [335:0] m_tdata,
  // status
  output logic [1:0]   m_tuser
);

  typedef struct packed {
    logic [30:0] rho;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] t;
    logic [31:0] pres;
    logic [31:0] enth;
    logic [31:0] ener;
    logic        negarg;
    logic        sat;
  } dl_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } s32_t;

  function automatic s32_t to_s32(input logic neg, input logic [63:0] mag);
    s32_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end else begin
      if (mag > 64'h8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'(0 - mag[31:0]);
      end
    end
    return r;
  endfunction

  function automatic s32_t sum_q16(input logic signed [63:0] s);
    logic [63:0] mag;
    mag = s[63] ? 64'(-s) : 64'(s);
    return to_s32(s[63], mag >> 16);
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? 32'(0 - v) : v;
  endfunction

  localparam logic [61:0] TERM_CAP = 62'd1 << 61;
  localparam logic [64:0] SARG_CAP = 65'd1 << 62;

  // configuration
  logic [30:0]      gas;
  logic [17:0]      heat;
  logic             div_start;
  logic             div_busy;
  logic [QBITS-1:0] inv;
  logic [17:0]      g;
  logic [17:0]      gm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gas       <= GAS_RESET;
      heat      <= HEAT_RESET;
      div_start <= 1'b1;
    end else begin
      div_start <= cfg_we && (cfg_index == REG_HEAT);
      if (cfg_we && cfg_index == REG_GAS) begin
        gas <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_HEAT) begin
        heat <= cfg_data[17:0];
      end
    end
  end

  assign g   = (heat < G_MIN) ? G_MIN : heat;
  assign gm1 = g - ONE_Q16;

  ep2p_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (gm1),
    .busy     (div_busy),
    .quotient (inv)
  );

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !div_busy && !div_start;

  // stage 1: products of the inputs
  logic [30:0] in_rho;
  logic [31:0] in_vx, in_vy, in_vz, in_t;
  assign in_rho = s_tdata[30:0];
  assign in_vx  = s_tdata[62:31];
  assign in_vy  = s_tdata[94:63];
  assign in_vz  = s_tdata[126:95];
  assign in_t   = s_tdata[158:127];

  logic        s1_vld;
  logic [30:0] s1_rho;
  logic [31:0] s1_vx, s1_vy, s1_vz, s1_t;
  logic [61:0] s1_rt;
  logic [63:0] s1_sqx, s1_sqy, s1_sqz;

  logic [31:0] mx, my, mz, tm;
  logic [62:0] rt_full;
  assign mx      = abs32(in_vx);
  assign my      = abs32(in_vy);
  assign mz      = abs32(in_vz);
  assign tm      = abs32(in_t);
  assign rt_full = gas * tm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rho <= in_rho;
      s1_vx  <= in_vx;
      s1_vy  <= in_vy;
      s1_vz  <= in_vz;
      s1_t   <= in_t;
      s1_rt  <= rt_full[61:0];
      s1_sqx <= mx * mx;
      s1_sqy <= my * my;
      s1_sqz <= mz * mz;
    end
  end

  // stage 2: partial products against R*T
  logic        s2_vld;
  logic [30:0] s2_rho;
  logic [31:0] s2_vx, s2_vy, s2_vz, s2_t;
  logic [61:0] s2_rt;
  logic [63:0] s2_v2;
  logic [62:0] s2_pr0;
  logic [60:0] s2_pr1;
  logic [49:0] s2_pg0;
  logic [47:0] s2_pg1;
  logic [63:0] s2_p00;
  logic [61:0] s2_p01;
  logic [48:0] s2_p10;
  logic [46:0] s2_p11;

  logic [31:0] r0;
  logic [29:0] r1;
  logic [31:0] i0;
  logic [16:0] i1;
  assign r0 = s1_rt[31:0];
  assign r1 = s1_rt[61:32];
  assign i0 = inv[31:0];
  assign i1 = inv[48:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rho <= s1_rho;
      s2_vx  <= s1_vx;
      s2_vy  <= s1_vy;
      s2_vz  <= s1_vz;
      s2_t   <= s1_t;
      s2_rt  <= s1_rt;
      s2_v2  <= s1_sqx + s1_sqy + s1_sqz;
      s2_pr0 <= s1_rho * r0;
      s2_pr1 <= s1_rho * r1;
      s2_pg0 <= g * r0;
      s2_pg1 <= g * r1;
      s2_p00 <= i0 * r0;
      s2_p01 <= i0 * r1;
      s2_p10 <= i1 * r0;
      s2_p11 <= i1 * r1;
    end
  end

  // stage 3: recombine, cap terms, pressure
  logic        s3_vld;
  logic [30:0] s3_rho;
  logic [31:0] s3_vx, s3_vy, s3_vz, s3_t;
  logic [63:0] s3_v2;
  logic [63:0] s3_sarg;
  logic [61:0] s3_a, s3_e, s3_half;
  logic [31:0] s3_pres;
  logic        s3_psat;
  logic        s3_negarg;

  logic [62:0] pmag;
  logic [64:0] sarg_raw;
  logic [79:0] e_raw, a_raw;
  logic [62:0] half_raw;
  s32_t        pconv;

  assign pmag     = 63'(s2_pr1) + 63'(s2_pr0 >> 32);
  assign sarg_raw = {1'b0, s2_pg1, 16'b0} + 65'(s2_pg0 >> 16);
  assign e_raw    = {1'b0, s2_p11, 32'b0} + 80'(s2_p10) + 80'(s2_p01) + 80'(s2_p00 >> 32);
  assign a_raw    = e_raw + 80'(s2_rt);
  assign half_raw = s2_v2[63:1];
  assign pconv    = to_s32(s2_t[31], {1'b0, pmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rho    <= s2_rho;
      s3_vx     <= s2_vx;
      s3_vy     <= s2_vy;
      s3_vz     <= s2_vz;
      s3_t      <= s2_t;
      s3_v2     <= s2_v2;
      s3_sarg   <= (sarg_raw > SARG_CAP) ? SARG_CAP[63:0] : sarg_raw[63:0];
      s3_e      <= (e_raw > 80'(TERM_CAP)) ? TERM_CAP : e_raw[61:0];
      s3_a      <= (a_raw > 80'(TERM_CAP)) ? TERM_CAP : a_raw[61:0];
      s3_half   <= (half_raw > 63'(TERM_CAP)) ? TERM_CAP : half_raw[61:0];
      s3_pres   <= pconv.val;
      s3_psat   <= pconv.sat;
      s3_negarg <= s2_t[31] && (s2_rt != '0);
    end
  end

  // stage 4 onward: sums to Q16.16, delayed alongside the square roots
  logic signed [63:0] hsum, esum;
  s32_t               hconv, econv;
  assign hsum  = (s3_t[31] ? -$signed({2'b0, s3_a}) : $signed({2'b0, s3_a}))
               + $signed({2'b0, s3_half});
  assign esum  = (s3_t[31] ? -$signed({2'b0, s3_e}) : $signed({2'b0, s3_e}))
               + $signed({2'b0, s3_half});
  assign hconv = sum_q16(hsum);
  assign econv = sum_q16(esum);

  dl_t  dl [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] dl_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_vld <= '0;
    end else if (adv) begin
      dl_vld <= {dl_vld[SQRT_STAGES-2:0], s3_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0].rho    <= s3_rho;
      dl[0].vx     <= s3_vx;
      dl[0].vy     <= s3_vy;
      dl[0].vz     <= s3_vz;
      dl[0].t      <= s3_t;
      dl[0].pres   <= s3_pres;
      dl[0].enth   <= hconv.val;
      dl[0].ener   <= econv.val;
      dl[0].negarg <= s3_negarg;
      dl[0].sat    <= s3_psat || hconv.sat || econv.sat;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  logic [31:0] root_snd, root_spd;

  ep2p_isqrt u_sqrt_snd (
    .clk      (clk),
    .en       (adv),
    .radicand (s3_sarg),
    .root     (root_snd)
  );

  ep2p_isqrt u_sqrt_spd (
    .clk      (clk),
    .en       (adv),
    .radicand (s3_v2),
    .root     (root_spd)
  );

  // output register
  dl_t         last;
  logic        snd_sat, spd_sat;
  logic [30:0] snd, spd;
  status_t     st;

  assign last    = dl[SQRT_STAGES-1];
  assign snd_sat = !last.negarg && root_snd[31];
  assign spd_sat = root_spd[31];
  assign snd     = last.negarg ? 31'd0 : (root_snd[31] ? 31'h7FFF_FFFF : root_snd[30:0]);
  assign spd     = root_spd[31] ? 31'h7FFF_FFFF : root_spd[30:0];

  always_comb begin
    if (last.negarg) begin
      st = ST_NEG_ARG;
    end else if (last.sat || snd_sat || spd_sat) begin
      st = ST_SAT;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dl_vld[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {1'b0, heat, last.vz, last.vy, last.vx, spd, last.t, snd,
                  last.ener, last.enth, last.pres, last.rho};
      m_tuser <= st;
    end
  end

endmodule

/* sv/ep2p_recip.sv */
// Bit-serial reciprocal: quotient = floor(2^48 / divisor), one bit per cycle.
// Depends on ep2p_pkg.
module ep2p_recip import ep2p_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [17:0]      divisor,
  output logic             busy,
  output logic [QBITS-1:0] quotient
);

  logic [5:0]  cnt;
  logic [17:0] rem;
  logic [18:0] rem_sh;
  logic        ge;
  logic [18:0] diff;

  assign rem_sh = {rem, (cnt == 6'(QBITS - 1))};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 6'(QBITS - 1);
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[17:0] : rem_sh[17:0];
      quotient <= {quotient[QBITS-2:0], ge};
      if (cnt == 6'd0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end

endmodule

/* sv/ep2p_isqrt.sv */
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Depends on ep2p_pkg.
module ep2p_isqrt import ep2p_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] xr [SQRT_STAGES];
  logic [63:0] rr [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [63:0] BITC = 64'd1 << (62 - 2 * j);
    logic [63:0] xi;
    logic [63:0] ri;
    logic [63:0] trial;

    if (j == 0) begin : g_first
      assign xi = radicand;
      assign ri = '0;
    end else begin : g_rest
      assign xi = xr[j-1];
      assign ri = rr[j-1];
    end

    assign trial = ri + BITC;

    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= trial) begin
          xr[j] <= xi - trial;
          rr[j] <= (ri >> 1) + BITC;
        end else begin
          xr[j] <= xi;
          rr[j] <= ri >> 1;
        end
      end
    end
  end

  assign root = rr[SQRT_STAGES-1][31:0];

endmodule
